@@ rtl/core/sitoa_pkg.sv @@
// ----------------------------------------------------------------------------
// sitoa_pkg
// shared types, constants and helpers for the signed integer to ascii block
// ----------------------------------------------------------------------------
package sitoa_pkg;

	localparam int unsigned VALUE_BITS_DEF = 32;
	localparam int unsigned BASE_BITS      = 6;
	localparam int unsigned CHAR_BITS      = 7;
	// quotient bits resolved per division cycle
	localparam int unsigned STEP_BITS      = 8;

	localparam logic [BASE_BITS-1:0] RADIX_MIN = 6'd2;
	localparam logic [BASE_BITS-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_SEVEN = 7'h37;
	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_BITS-1:0] CHAR_NONE  = 7'h00;
	localparam logic [BASE_BITS-1:0] DIGIT_TEN  = 6'd10;

	// classification of one accepted transaction
	typedef struct packed {
		logic                 err;
		logic                 neg;
		logic [BASE_BITS-1:0] base;
	} sitoa_class_t;

	function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [BASE_BITS-1:0] d);
		logic [CHAR_BITS-1:0] dz;
		dz = {1'b0, d};
		if (d < DIGIT_TEN) begin
			return CHAR_ZERO + dz;
		end
		return CHAR_SEVEN + dz;
	endfunction

endpackage

@@ rtl/core/signed_int_to_ascii_radix.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_ascii_radix
// signed integer to ascii text in any base from 2 to 36
// ----------------------------------------------------------------------------
// Each input transaction carries a two's-complement value and a base; the
// block returns the text of the value one character per output transaction,
// most significant character first, with last set on the final character.
// A negative value starts with '-'. Digits above nine use 'A' to 'Z'. A base
// outside 2..36 gives a single transaction with text_char 0, last and error
// set. Digits are produced by repeated division of the magnitude by the
// base, eight quotient bits per cycle; the digits are stacked and then
// sent out at one character per cycle while the output is not stalled.
// A two-entry queue in front of the engine takes new numbers while the
// previous one is still being converted.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_radix import sitoa_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// number input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [BASE_BITS-1:0]  base,
	// character output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CHAR_BITS-1:0]  text_char,
	output logic                  last,
	output logic                  error
);

	localparam int unsigned JOB_BITS = $bits(sitoa_class_t) + VALUE_BITS;

	sitoa_class_t          front_cls;
	logic [VALUE_BITS-1:0] front_mag;
	logic                  job_valid;
	logic                  job_pop;
	logic [JOB_BITS-1:0]   job_data;
	sitoa_class_t          job_cls;
	logic [VALUE_BITS-1:0] job_mag;

	// front: range check, sign and magnitude of the incoming transaction
	sitoa_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.value (value),
		.base  (base),
		.cls   (front_cls),
		.mag   (front_mag)
	);

	// short queue so the front keeps accepting while the engine is busy
	sitoa_queue #(
		.DATA_BITS (JOB_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (in_stall),
		.push_data  ({front_cls, front_mag}),
		.pop_valid  (job_valid),
		.pop        (job_pop),
		.pop_data   (job_data)
	);

	assign job_cls = job_data[JOB_BITS-1:VALUE_BITS];
	assign job_mag = job_data[VALUE_BITS-1:0];

	// back: division by the base, digit stack and registered character output
	sitoa_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job_cls   (job_cls),
		.job_mag   (job_mag),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.last      (last),
		.error     (error)
	);

endmodule

@@ rtl/core/sitoa_front.sv @@
// ----------------------------------------------------------------------------
// sitoa_front
// classifies an incoming number: base range check, sign and magnitude
// ----------------------------------------------------------------------------
module sitoa_front import sitoa_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic [VALUE_BITS-1:0] value,
	input  logic [BASE_BITS-1:0]  base,
	output sitoa_class_t          cls,
	output logic [VALUE_BITS-1:0] mag
);

	logic neg;

	assign neg = value[VALUE_BITS-1];

	// two's complement negate; most negative value maps to 2^(n-1) unsigned
	assign mag = neg ? (~value + VALUE_BITS'(1)) : value;

	always_comb begin
		cls.err  = (base < RADIX_MIN) || (base > RADIX_MAX);
		cls.neg  = neg;
		cls.base = base;
	end

endmodule

@@ rtl/core/sitoa_queue.sv @@
// ----------------------------------------------------------------------------
// sitoa_queue
// two-entry queue decoupling the classifier from the digit engine
// ----------------------------------------------------------------------------
module sitoa_queue import sitoa_pkg::*; #(
	parameter int unsigned DATA_BITS = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_stall,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 pop_valid,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] pop_data
);

	logic [DATA_BITS-1:0] entry_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_stall = (count_q == 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/sitoa_back.sv @@
// ----------------------------------------------------------------------------
// sitoa_back
// digit engine: repeated division by the base, digit stack, character output
// ----------------------------------------------------------------------------
module sitoa_back import sitoa_pkg::*; #(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_pop,
	input  sitoa_class_t          job_cls,
	input  logic [VALUE_BITS-1:0] job_mag,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CHAR_BITS-1:0]  text_char,
	output logic                  last,
	output logic                  error
);

	localparam int unsigned CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int unsigned PAD_BITS = CHUNKS * STEP_BITS;
	localparam int unsigned CW       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int unsigned DW       = $clog2(VALUE_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT,
		ST_ERR
	} state_t;

	state_t                 state_q;
	logic [PAD_BITS-1:0]    div_q;
	logic [BASE_BITS-1:0]   rem_q;
	logic [BASE_BITS-1:0]   base_q;
	logic                   neg_q;
	logic [CW-1:0]          chunk_q;
	logic [DW-1:0]          depth_q;
	logic [BASE_BITS-1:0]   stk_q [VALUE_BITS];

	logic                   out_valid_q;
	logic [CHAR_BITS-1:0]   text_char_q;
	logic                   last_q;
	logic                   error_q;

	logic                   ofree;
	logic                   last_chunk;
	logic                   push;
	logic                   pop_stk;
	logic [STEP_BITS-1:0]   qbits;
	logic [BASE_BITS-1:0]   rem_next;
	logic [PAD_BITS-1:0]    div_next;

	assign ofree      = !out_valid_q || !out_stall;
	assign job_pop    = (state_q == ST_IDLE) && job_valid;
	assign last_chunk = (chunk_q == CW'(CHUNKS - 1));
	assign push       = (state_q == ST_DIV) && last_chunk;
	assign pop_stk    = (state_q == ST_EMIT) && ofree;

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last      = last_q;
	assign error     = error_q;

	// restoring division of one chunk, most significant bit first
	always_comb begin
		logic [BASE_BITS:0]   t;
		logic [BASE_BITS-1:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, div_q[PAD_BITS-1-i]};
			if (t >= {1'b0, base_q}) begin
				qbits[STEP_BITS-1-i] = 1'b1;
				r = BASE_BITS'(t - {1'b0, base_q});
			end else begin
				r = t[BASE_BITS-1:0];
			end
		end
		rem_next = r;
		div_next = (div_q << STEP_BITS) | PAD_BITS'(qbits);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_q       <= '0;
			rem_q       <= '0;
			base_q      <= '0;
			neg_q       <= 1'b0;
			chunk_q     <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
			text_char_q <= CHAR_NONE;
			last_q      <= 1'b0;
			error_q     <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						div_q   <= PAD_BITS'(job_mag);
						rem_q   <= '0;
						base_q  <= job_cls.base;
						neg_q   <= job_cls.neg;
						chunk_q <= '0;
						depth_q <= '0;
						state_q <= job_cls.err ? ST_ERR : ST_DIV;
					end
				end
				ST_DIV: begin
					div_q <= div_next;
					if (last_chunk) begin
						depth_q <= depth_q + DW'(1);
						rem_q   <= '0;
						chunk_q <= '0;
						if (div_next == '0) begin
							state_q <= neg_q ? ST_SIGN : ST_EMIT;
						end
					end else begin
						rem_q   <= rem_next;
						chunk_q <= chunk_q + CW'(1);
					end
				end
				ST_SIGN: begin
					if (ofree) begin
						out_valid_q <= 1'b1;
						text_char_q <= CHAR_MINUS;
						last_q      <= 1'b0;
						error_q     <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (ofree) begin
						out_valid_q <= 1'b1;
						text_char_q <= digit_to_ascii(stk_q[0]);
						last_q      <= (depth_q == DW'(1));
						error_q     <= 1'b0;
						depth_q     <= depth_q - DW'(1);
						if (depth_q == DW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (ofree) begin
						out_valid_q <= 1'b1;
						text_char_q <= CHAR_NONE;
						last_q      <= 1'b1;
						error_q     <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digit stack: pushed least significant digit first, popped from the top
	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= rem_next;
			for (int i = 1; i < VALUE_BITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (pop_stk) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_q |-> last_q && (text_char_q == CHAR_NONE))
		else $error("error character not marked last");

	a_emit_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) || (state_q == ST_SIGN) |-> depth_q != '0)
		else $error("emitting with an empty digit stack");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(VALUE_BITS))
		else $error("digit stack overflow");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> rem_q < base_q)
		else $error("partial remainder not below the base");

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && ofree && (depth_q == DW'(1)) |=> (state_q == ST_IDLE))
		else $error("final character did not end the transaction");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the signed integer to ascii block
// ----------------------------------------------------------------------------
// A short table of numbers covers the edges: zero, plus and minus one, the
// largest and the most negative value, the smallest and largest bases, and
// bases that are out of range. Some rows carry their text typed in. The
// rest, and the random numbers after them, are spelt out by a local model
// of the conversion. Every accepted character is checked against the oldest
// expected one. Both sides pause at random in two of three phases. One
// long receiver hold-off lets the block fill up and push back on its input.
// ----------------------------------------------------------------------------
module tb_top;
	import sitoa_pkg::*;

	localparam int unsigned NUM_BITS     = 32;
	localparam int          RANDOM_ITEMS = 152;	// per phase
	localparam int          HOLD_CYCLES  = 400;
	localparam int          QUIET_LIMIT  = 4000;
	localparam int          TAIL_CYCLES  = 200;	// longer than a base-2 number

	// where the expected text of one table row comes from
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TEXT,
		ROW_BAD_BASE
	} row_kind_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] ch;
		logic                 fin;
		logic                 err;
	} glyph_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [NUM_BITS-1:0]  value;
	logic [BASE_BITS-1:0] base;
	logic                 out_valid;
	logic                 out_stall;
	logic [CHAR_BITS-1:0] text_char;
	logic                 last;
	logic                 error;

	// characters still owed by the block, oldest first
	glyph_t expected_chars[$];

	// directed table
	logic [NUM_BITS-1:0]  row_value[$];
	logic [BASE_BITS-1:0] row_base[$];
	row_kind_t            row_kind[$];
	string                row_text[$];

	// describes the transaction currently on offer
	row_kind_t cur_kind;
	string     cur_text;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;

	int          fault_count;
	int          numbers_taken;
	int          negatives_taken;
	int          bad_bases_taken;
	int          chars_checked;
	int          run_len;
	int          longest_text;
	logic [63:0] bases_seen;

	signed_int_to_ascii_radix #(
		.VALUE_BITS(NUM_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.base     (base),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.text_char(text_char),
		.last     (last),
		.error    (error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// conversion model: sign, then digits of the magnitude, most significant first
	function automatic void spell_number(input logic [NUM_BITS-1:0] num,
			input logic [BASE_BITS-1:0] radix);
		logic [NUM_BITS-1:0]  mag;
		logic [BASE_BITS-1:0] d;
		logic [CHAR_BITS-1:0] digit_buf[0:NUM_BITS];
		int                   n;
		glyph_t               g;
		if (radix < RADIX_MIN || radix > RADIX_MAX) begin
			g = '{ch: CHAR_NONE, fin: 1'b1, err: 1'b1};
			expected_chars.push_back(g);
			return;
		end
		// the most negative value wraps onto itself, read unsigned it is 2^31
		mag = num[NUM_BITS-1] ? (~num + 1'b1) : num;
		n = 0;
		do begin
			d = BASE_BITS'(mag % NUM_BITS'(radix));
			digit_buf[n] = (d < DIGIT_TEN) ? (CHAR_ZERO + {1'b0, d}) : (CHAR_SEVEN + {1'b0, d});
			n++;
			mag = mag / NUM_BITS'(radix);
		end while (mag != '0);
		if (num[NUM_BITS-1]) begin
			g = '{ch: CHAR_MINUS, fin: 1'b0, err: 1'b0};
			expected_chars.push_back(g);
		end
		for (int k = n - 1; k >= 0; k--) begin
			g.ch  = digit_buf[k];
			g.fin = (k == 0);
			g.err = 1'b0;
			expected_chars.push_back(g);
		end
	endfunction

	task automatic table_row(input logic [NUM_BITS-1:0] v, input logic [BASE_BITS-1:0] b,
			input row_kind_t k, input string s);
		row_value.push_back(v);
		row_base.push_back(b);
		row_kind.push_back(k);
		row_text.push_back(s);
	endtask

	task automatic flag_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		fault_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	// offer one number at a falling edge and hold it until it is taken
	task automatic offer_number(input logic [NUM_BITS-1:0] v, input logic [BASE_BITS-1:0] b,
			input row_kind_t k, input string s);
		cur_kind = k;
		cur_text = s;
		in_valid <= 1'b1;
		value    <= v;
		base     <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// stop offering until every owed character has come out
	task automatic wait_all_chars();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_chars.size() != 0);
	endtask

	// receiver: random stalls, or a long counted hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// both handshakes are sampled here, so expectations always go in before
	// the characters that answer them are taken out
	always @(posedge clk) begin : scoreboard
		glyph_t want;
		if (arst_n) begin
			if (in_valid && in_stall === 1'b0) begin
				numbers_taken++;
				bases_seen[base] = 1'b1;
				if (value[NUM_BITS-1]) begin
					negatives_taken++;
				end
				if (base < RADIX_MIN || base > RADIX_MAX) begin
					bad_bases_taken++;
				end
				case (cur_kind)
					ROW_TEXT: begin
						for (int i = 0; i < cur_text.len(); i++) begin
							want.ch  = CHAR_BITS'(cur_text[i]);
							want.fin = (i == cur_text.len() - 1);
							want.err = 1'b0;
							expected_chars.push_back(want);
						end
					end
					ROW_BAD_BASE: begin
						want = '{ch: CHAR_NONE, fin: 1'b1, err: 1'b1};
						expected_chars.push_back(want);
					end
					default: begin
						spell_number(value, base);
					end
				endcase
			end
			if (out_valid !== 1'b0 && out_valid !== 1'b1) begin
				flag_mismatch("out_valid", 32'd0, {31'd0, out_valid});
			end else if (out_valid && !out_stall) begin
				chars_checked++;
				run_len++;
				if (last === 1'b1) begin
					if (run_len > longest_text) begin
						longest_text = run_len;
					end
					run_len = 0;
				end
				if (expected_chars.size() == 0) begin
					fault_count++;
					$display("%0t: unexpected character, expected none, actual %h last %b error %b",
						$time, text_char, last, error);
				end else begin
					want = expected_chars.pop_front();
					if (text_char !== want.ch) begin
						flag_mismatch("text_char", {25'd0, want.ch}, {25'd0, text_char});
					end
					if (last !== want.fin) begin
						flag_mismatch("last", {31'd0, want.fin}, {31'd0, last});
					end
					if (error !== want.err) begin
						flag_mismatch("error", {31'd0, want.err}, {31'd0, error});
					end
				end
			end
		end
	end

	// watchdog: ends the run when nothing moves on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("timeout: %0d cycles with no transaction", QUIET_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [NUM_BITS-1:0]  v;
		logic [BASE_BITS-1:0] b;
		int                   pick;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		value           = '0;
		base            = '0;
		cur_kind        = ROW_PREDICT;
		cur_text        = "";
		hold_request    = 1'b0;
		fault_count     = 0;
		numbers_taken   = 0;
		negatives_taken = 0;
		bad_bases_taken = 0;
		chars_checked   = 0;
		run_len         = 0;
		longest_text    = 0;
		bases_seen      = '0;
		send_idle_pct   = 16;
		recv_stall_pct  = 59;

		// zeros, ones and the extremes of value and base
		table_row(32'd0,          6'd10, ROW_TEXT,     "0");
		table_row(32'd0,          6'd2,  ROW_TEXT,     "0");
		table_row(32'd0,          6'd36, ROW_TEXT,     "0");
		table_row(32'd1,          6'd2,  ROW_TEXT,     "1");
		table_row(32'hFFFF_FFFF,  6'd10, ROW_TEXT,     "-1");
		table_row(32'hFFFF_FFFF,  6'd2,  ROW_TEXT,     "-1");
		table_row(32'h7FFF_FFFF,  6'd10, ROW_TEXT,     "2147483647");
		table_row(32'h8000_0000,  6'd10, ROW_TEXT,     "-2147483648");
		table_row(32'h7FFF_FFFF,  6'd16, ROW_TEXT,     "7FFFFFFF");
		table_row(32'h8000_0000,  6'd16, ROW_TEXT,     "-80000000");
		// most negative in binary is the longest text of all
		table_row(32'h8000_0000,  6'd2,  ROW_PREDICT,  "");
		table_row(32'h7FFF_FFFF,  6'd2,  ROW_PREDICT,  "");
		table_row(32'h7FFF_FFFF,  6'd36, ROW_PREDICT,  "");
		table_row(32'h8000_0000,  6'd36, ROW_PREDICT,  "");
		// letter digits, top and bottom of the range
		table_row(32'd35,         6'd36, ROW_TEXT,     "Z");
		table_row(-32'sd35,       6'd36, ROW_TEXT,     "-Z");
		table_row(32'd10,         6'd11, ROW_TEXT,     "A");
		table_row(32'd255,        6'd16, ROW_TEXT,     "FF");
		// bases out of range on both sides
		table_row(32'd123,        6'd0,  ROW_BAD_BASE, "");
		table_row(-32'sd5,        6'd1,  ROW_BAD_BASE, "");
		table_row(32'h8000_0000,  6'd37, ROW_BAD_BASE, "");
		table_row(32'h7FFF_FFFF,  6'd63, ROW_BAD_BASE, "");
		table_row(32'd12345,      6'd7,  ROW_PREDICT,  "");
		table_row(-32'sd12345,    6'd8,  ROW_PREDICT,  "");
		table_row(32'd100,        6'd3,  ROW_PREDICT,  "");

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < row_value.size(); r++) begin
			offer_number(row_value[r], row_base[r], row_kind[r], row_text[r]);
			sender_gap();
		end
		wait_all_chars();

		// phases: sender idles lightly, then receiver lightly, then nobody idles
		for (int p = 0; p < 3; p++) begin
			send_idle_pct  = (p == 0) ? 16 : (p == 1) ? 59 : 0;
			recv_stall_pct = (p == 0) ? 59 : (p == 1) ? 16 : 0;
			// long hold-off with numbers still pouring in, so the input backs up
			if (p == 2) begin
				hold_request = 1'b1;
			end
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					b = $urandom_range(0, 1) ? BASE_BITS'($urandom_range(0, 1))
						: BASE_BITS'($urandom_range(37, 63));
				end else if (pick < 30) begin
					case ($urandom_range(0, 3))
						0: b = 6'd2;
						1: b = 6'd10;
						2: b = 6'd16;
						default: b = 6'd36;
					endcase
				end else begin
					b = BASE_BITS'($urandom_range(2, 36));
				end
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					v = $urandom;
				end else if (pick < 60) begin
					v = NUM_BITS'($urandom_range(0, 1000));
				end else if (pick < 80) begin
					v = $urandom >> $urandom_range(0, 31);
				end else if (pick < 90) begin
					case ($urandom_range(0, 3))
						0: v = 32'd0;
						1: v = 32'h8000_0000;
						2: v = 32'h7FFF_FFFF;
						default: v = 32'hFFFF_FFFF;
					endcase
				end else begin
					v = 32'd1 << $urandom_range(0, 31);
				end
				if (pick >= 40 && pick < 80 && $urandom_range(0, 1)) begin
					v = -v;
				end
				offer_number(v, b, ROW_PREDICT, "");
				sender_gap();
			end
			wait_all_chars();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d numbers (%0d negative, %0d with a bad base), %0d characters checked",
			numbers_taken, negatives_taken, bad_bases_taken, chars_checked);
		$display("%0d of 64 base codes used, longest text %0d characters, %0d faults",
			$countones(bases_seen), longest_text, fault_count);
		if (fault_count == 0 && expected_chars.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
